@@ rtl/psue_pkg.sv @@
package psue_pkg;

   localparam int PARTICLES_DEF = 32;
   localparam int COMPONENTS_DEF = 6;
   localparam int VEC_SLOTS = 6;
   localparam int CW = 16;
   localparam int VEC_W = VEC_SLOTS * CW;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic signed [CW-1:0] VMAX = 16'sd2048;

   typedef enum logic [2:0] {
      OP_LOAD_POS  = 3'd0,
      OP_LOAD_VEL  = 3'd1,
      OP_REPORT    = 3'd2,
      OP_MOVE      = 3'd3,
      OP_READ_BEST = 3'd4,
      OP_CLEAR     = 3'd5
   } op_type;

   localparam logic [1:0] CSR_C1 = 2'd0;
   localparam logic [1:0] CSR_C2 = 2'd1;
   localparam logic [1:0] CSR_PMIN = 2'd2;
   localparam logic [1:0] CSR_PMAX = 2'd3;

   typedef struct packed {
      logic [2:0]        op;
      logic [7:0]        particle;
      logic [VEC_W-1:0]  value;
      logic [31:0]       fitness;
      logic [15:0]       inertia;
      logic [15:0]       rand_one;
      logic [15:0]       rand_two;
   } req_type;

   typedef struct packed {
      logic [7:0]        particle;
      logic [VEC_W-1:0]  vec;
      logic [31:0]       best_fitness;
      logic              new_personal_best;
      logic              new_global_best;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request, issue memory read
      logic execute;   // apply operation, write stores
      logic calc;      // move arithmetic stage
      logic respond;   // load response register
   } cmd_type;

endpackage

@@ rtl/psue_if.sv @@
interface psue_req_if;
   import psue_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [4:0]  particle;
   logic signed [15:0] value_wire;
   logic signed [15:0] value_via;
   logic signed [15:0] value_congestion;
   logic signed [15:0] value_drc_history;
   logic signed [15:0] value_layer;
   logic signed [15:0] value_timing;
   logic [31:0] fitness;
   logic [15:0] inertia;
   logic [15:0] rand_one;
   logic [15:0] rand_two;
   modport source (output valid, op, particle, value_wire, value_via, value_congestion,
      value_drc_history, value_layer, value_timing, fitness, inertia, rand_one, rand_two,
      input ready);
   modport sink (input valid, op, particle, value_wire, value_via, value_congestion,
      value_drc_history, value_layer, value_timing, fitness, inertia, rand_one, rand_two,
      output ready);
endinterface

interface psue_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  out_particle;
   logic signed [15:0] out_wire;
   logic signed [15:0] out_via;
   logic signed [15:0] out_congestion;
   logic signed [15:0] out_drc_history;
   logic signed [15:0] out_layer;
   logic signed [15:0] out_timing;
   logic [31:0] best_fitness;
   logic        new_personal_best;
   logic        new_global_best;
   modport source (output valid, out_particle, out_wire, out_via, out_congestion,
      out_drc_history, out_layer, out_timing, best_fitness, new_personal_best,
      new_global_best, input ready);
   modport sink (input valid, out_particle, out_wire, out_via, out_congestion,
      out_drc_history, out_layer, out_timing, best_fitness, new_personal_best,
      new_global_best, output ready);
endinterface

@@ rtl/particle_swarm_update_engine_unit.sv @@
// Particle swarm update engine: keeps position, velocity and personal best for each
// particle plus one global best, and answers every request with exactly one response.
// Requests are handled one at a time. When a request is accepted the particle's stores
// are read; the move arithmetic is then registered; last, the stores are committed and
// the response register is loaded. Ready comes back in the same cycle as the response
// is offered. The controller keeps only one request in flight, so a new request is not
// taken until the last one has loaded its response. A response that is not taken holds
// the next request in its arithmetic stage until the response register frees up. Write
// configuration only while idle.
module particle_swarm_update_engine_unit import psue_pkg::*; #(
   parameter int PARTICLES  = PARTICLES_DEF,
   parameter int COMPONENTS = COMPONENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   psue_req_if.sink    req,
   psue_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   logic [15:0] c1_ff, c2_ff;
   logic signed [15:0] pmin_ff, pmax_ff;
   cmd_type cmd;
   req_type rq;
   rsp_type rs;

   // hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff   <= 16'd16384;
         c2_ff   <= 16'd16384;
         pmin_ff <= 16'sd0;
         pmax_ff <= 16'sd32767;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_C1:   c1_ff   <= csr_write_data;
            CSR_C2:   c2_ff   <= csr_write_data;
            CSR_PMIN: pmin_ff <= csr_write_data;
            CSR_PMAX: pmax_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign rq.op       = req.op;
   assign rq.particle = {3'd0, req.particle};
   assign rq.value    = {req.value_timing, req.value_layer, req.value_drc_history,
                         req.value_congestion, req.value_via, req.value_wire};
   assign rq.fitness  = req.fitness;
   assign rq.inertia  = req.inertia;
   assign rq.rand_one = req.rand_one;
   assign rq.rand_two = req.rand_two;

   psue_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd
   );

   psue_dp #(.PARTICLES(PARTICLES), .COMPONENTS(COMPONENTS)) u_dp (
      .clock, .reset, .cmd, .req(rq),
      .c1(c1_ff), .c2(c2_ff), .pmin(pmin_ff), .pmax(pmax_ff),
      .rsp(rs)
   );

   assign rsp.out_particle      = rs.particle[4:0];
   assign rsp.out_wire          = rs.vec[0*CW +: CW];
   assign rsp.out_via           = rs.vec[1*CW +: CW];
   assign rsp.out_congestion    = rs.vec[2*CW +: CW];
   assign rsp.out_drc_history   = rs.vec[3*CW +: CW];
   assign rsp.out_layer         = rs.vec[4*CW +: CW];
   assign rsp.out_timing        = rs.vec[5*CW +: CW];
   assign rsp.best_fitness      = rs.best_fitness;
   assign rsp.new_personal_best = rs.new_personal_best;
   assign rsp.new_global_best   = rs.new_global_best;
endmodule

@@ rtl/psue_ctrl.sv @@
module psue_ctrl import psue_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);
   typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_EXEC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.capture  = req_fire;
      case (state_ff)
         S_IDLE: if (req_fire) state_in = S_READ;
         S_READ: begin
            cmd.calc = 1'b1;
            state_in = S_CALC;
         end
         S_CALC: begin
            // wait for the output register to be free before committing
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.execute  = 1'b1;
               cmd.respond  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

@@ rtl/psue_dp.sv @@
module psue_dp import psue_pkg::*; #(
   parameter int PARTICLES  = PARTICLES_DEF,
   parameter int COMPONENTS = COMPONENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  req_type     req,
   input  logic [15:0] c1,
   input  logic [15:0] c2,
   input  logic signed [15:0] pmin,
   input  logic signed [15:0] pmax,
   output rsp_type     rsp
);
   localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

   logic [VEC_W-1:0] pos_mem [PARTICLES];
   logic [VEC_W-1:0] vel_mem [PARTICLES];
   logic [VEC_W-1:0] pb_mem  [PARTICLES];
   logic [31:0]      pbc_mem [PARTICLES];
   logic [PARTICLES-1:0] pbc_valid_ff;

   req_type          r_ff;
   logic [VEC_W-1:0] pos_rd_ff, vel_rd_ff, pb_rd_ff;
   logic [31:0]      pbc_rd_ff;
   logic             pbc_v_ff;
   logic [VEC_W-1:0] gbv_ff;
   logic [31:0]      gbc_ff;
   logic [VEC_W-1:0] newpos_ff, newvel_ff;
   logic [31:0]      g1_ff, g2_ff;
   rsp_type          rsp_ff;

   logic [AW-1:0] ra, wa;
   logic          in_range;
   logic [31:0]   pbc_cur;

   assign ra       = req.particle[AW-1:0];
   assign wa       = r_ff.particle[AW-1:0];
   assign in_range = ({24'd0, r_ff.particle} < 32'(PARTICLES));
   assign pbc_cur  = pbc_v_ff ? pbc_rd_ff : ALL_ONES;
   assign rsp      = rsp_ff;

   // capture request and read the particle's stores
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         r_ff      <= req;
         pos_rd_ff <= pos_mem[ra];
         vel_rd_ff <= vel_mem[ra];
         pb_rd_ff  <= pb_mem[ra];
         pbc_rd_ff <= pbc_mem[ra];
         pbc_v_ff  <= pbc_valid_ff[ra];
         g1_ff     <= 32'(c1) * 32'(req.rand_one);
         g2_ff     <= 32'(c2) * 32'(req.rand_two);
      end
   end

   // move arithmetic, one lane per component
   logic [VEC_W-1:0] np_c, nv_c;
   always_comb begin
      logic signed [16:0] x, v, pb, gb, d1, d2;
      logic signed [63:0] s, nv, xp;
      np_c = '0;
      nv_c = '0;
      for (int c = 0; c < VEC_SLOTS; c++) begin
         x  = 17'(signed'(pos_rd_ff[c*CW +: CW]));
         v  = 17'(signed'(vel_rd_ff[c*CW +: CW]));
         pb = 17'(signed'(pb_rd_ff[c*CW +: CW]));
         gb = 17'(signed'(gbv_ff[c*CW +: CW]));
         d1 = pb - x;
         d2 = gb - x;
         s  = (64'(v) * signed'({48'd0, r_ff.inertia}) <<< 14)
            + 64'(d1) * signed'({32'd0, g1_ff})
            + 64'(d2) * signed'({32'd0, g2_ff});
         nv = (s + (64'sd1 <<< 28)) >>> 29;
         if (nv > 64'sd2048) nv = 64'sd2048;
         if (nv < -64'sd2048) nv = -64'sd2048;
         xp = 64'(x) + nv;
         if (xp < 64'(pmin)) xp = 64'(pmin);
         else if (xp > 64'(pmax)) xp = 64'(pmax);
         if (c < COMPONENTS) begin
            nv_c[c*CW +: CW] = nv[CW-1:0];
            np_c[c*CW +: CW] = xp[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         newpos_ff <= np_c;
         newvel_ff <= nv_c;
      end
   end

   logic [VEC_W-1:0] ld_vec;
   always_comb begin
      ld_vec = '0;
      for (int c = 0; c < COMPONENTS; c++) ld_vec[c*CW +: CW] = r_ff.value[c*CW +: CW];
   end

   logic npb, ngb;
   assign npb = (r_ff.op == OP_REPORT) && in_range && (r_ff.fitness < pbc_cur);
   assign ngb = (r_ff.op == OP_REPORT) && in_range && (r_ff.fitness < gbc_ff);

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.execute && in_range) begin
         case (r_ff.op)
            OP_LOAD_POS: begin
               pos_mem[wa] <= ld_vec;
               pb_mem[wa]  <= ld_vec;
            end
            OP_LOAD_VEL: vel_mem[wa] <= ld_vec;
            OP_REPORT: if (npb) begin
               pb_mem[wa]  <= pos_rd_ff;
               pbc_mem[wa] <= r_ff.fitness;
            end
            OP_MOVE: begin
               pos_mem[wa] <= newpos_ff;
               vel_mem[wa] <= newvel_ff;
            end
            default: ;
         endcase
      end
   end

   // personal best valid bits and global best
   always_ff @(posedge clock) begin
      if (reset) begin
         pbc_valid_ff <= '0;
         gbv_ff       <= '0;
         gbc_ff       <= ALL_ONES;
      end else if (cmd.execute) begin
         if (in_range && r_ff.op == OP_LOAD_POS) pbc_valid_ff[wa] <= 1'b0;
         if (npb) pbc_valid_ff[wa] <= 1'b1;
         if (ngb) begin
            gbc_ff <= r_ff.fitness;
            gbv_ff <= pos_rd_ff;
         end
         if (r_ff.op == OP_CLEAR) begin
            gbc_ff <= ALL_ONES;
            gbv_ff <= '0;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.particle          <= r_ff.particle;
         rsp_ff.new_personal_best <= npb;
         rsp_ff.new_global_best   <= ngb;
         rsp_ff.best_fitness      <= ngb ? r_ff.fitness : gbc_ff;
         case (r_ff.op)
            OP_LOAD_POS: rsp_ff.vec <= in_range ? ld_vec : '0;
            OP_LOAD_VEL, OP_REPORT: rsp_ff.vec <= in_range ? pos_rd_ff : '0;
            OP_MOVE: rsp_ff.vec <= in_range ? newpos_ff : '0;
            OP_CLEAR: begin
               rsp_ff.vec          <= '0;
               rsp_ff.best_fitness <= ALL_ONES;
            end
            default: rsp_ff.vec <= gbv_ff;
         endcase
      end
   end
endmodule
